[hw/rtl/windowed_moving_average_core_defines.svh]
// Assertion macros shared by the windowed moving average RTL.
// No dependencies; included by the top level only.
`ifndef WINDOWED_MOVING_AVERAGE_CORE_DEFINES_SVH
`define WINDOWED_MOVING_AVERAGE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold outside reset.
`define WMA_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
    else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define WMA_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define WMA_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`define WMA_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

[hw/rtl/wma_pkg.sv]
// Shared types and constants for the windowed moving average block.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package wma_pkg;

  // Sample and register widths.
  localparam int SAMPLE_W      = 32;
  localparam int CFG_W         = 8;
  localparam int DEPTH_DEFAULT = 128;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 8'd10;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;

  // Classified command kinds carried through the queue.
  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_FILL   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  value;
  } queue_item_t;

  // Status reported by the back part to the front part.
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

[hw/rtl/wma_front.sv]
// Front part: accepts input requests, classifies the operation and
// forwards legal commands to the queue. Depends on wma_pkg.
`default_nettype none

module wma_front (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_operation,
  input  wire logic signed [31:0]             in_value,
  input  wire wma_pkg::back_status_t          status,
  input  wire logic                           q_ready,
  output logic                                q_push,
  output wma_pkg::queue_item_t                q_item
);
  import wma_pkg::*;

  logic op_legal;

  // Requests are held off while the store is being cleared after reset.
  assign in_ready = q_ready && !status.clearing;

  // Decode the operation; the unused code is accepted and dropped.
  always_comb begin
    op_legal     = 1'b1;
    q_item.value = in_value;
    q_item.kind  = KIND_REPORT;
    case (in_operation)
      OP_PUSH:   q_item.kind = KIND_PUSH;
      OP_REPORT: q_item.kind = KIND_REPORT;
      OP_FILL:   q_item.kind = KIND_FILL;
      default:   op_legal = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && op_legal;

endmodule

`default_nettype wire

[hw/rtl/wma_queue.sv]
// Short command queue between the front and back parts.
// Depends on wma_pkg for the entry type and depth.
`default_nettype none

module wma_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire wma_pkg::queue_item_t  push_item,
  output logic                       ready,
  input  wire logic                  pop,
  output logic                       valid,
  output wma_pkg::queue_item_t       head
);
  import wma_pkg::*;

  localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t       entries_r [QUEUE_DEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;

  assign ready = (count_r != CNTW'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wma_back.sv]
// Back part: sample store, write index, summing walk, serial divider and
// result register. Depends on wma_pkg.
`default_nettype none

module wma_back #(
  parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [7:0]            window_length,
  input  wire logic                  q_valid,
  input  wire wma_pkg::queue_item_t  q_item,
  output logic                       q_pop,
  output wma_pkg::back_status_t      status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [31:0]         out_average
);
  import wma_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int WW   = $clog2(DEPTH + 1);
  localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;
  localparam int SW   = SAMPLE_W + 1 + AW;
  localparam int DCW  = $clog2(SW);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PUSH   = 8'b0000_0010,
    S_SUM    = 8'b0000_0100,
    S_LAST   = 8'b0000_1000,
    S_DSETUP = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_OUT    = 8'b0100_0000,
    S_SWEEP  = 8'b1000_0000
  } state_t;

  // Sample store.
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SAMPLE_W-1:0] rdata_r;

  // Control state.
  state_t              state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [WW-1:0]       idx_r, idx_nxt;
  logic                clearing_r, clearing_nxt;
  logic [SAMPLE_W-1:0] data_r, data_nxt;
  logic                rvld_r;
  logic                out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic [SW-1:0]        dvd_r, dvd_nxt;
  logic [WW-1:0]        rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic signed [31:0]   out_average_r, out_average_nxt;

  logic [CMPW-1:0]      wl_ext;
  logic [WW-1:0]        win;
  logic [WW-1:0]        idx_eff;
  logic [WW:0]          rem_sh;
  logic [WW:0]          win_ext;
  logic [SW-1:0]        rdata_ext;
  logic                 out_load;

  // Clamp the window to 1..DEPTH.
  always_comb begin
    wl_ext = CMPW'(window_length);
    if (wl_ext == '0) begin
      win = WW'(1);
    end else if (wl_ext > CMPW'(DEPTH)) begin
      win = WW'(DEPTH);
    end else begin
      win = WW'(wl_ext);
    end
  end

  // The write index wraps before the write when at or past the window.
  assign idx_eff   = (idx_r >= win) ? '0 : idx_r;
  assign win_ext   = {1'b0, win};
  assign rem_sh    = {rem_r, dvd_r[SW-1]};
  assign rdata_ext = {{(SW-SAMPLE_W){rdata_r[SAMPLE_W-1]}}, rdata_r};

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    clearing_nxt    = clearing_r;
    data_nxt        = data_r;
    acc_nxt         = acc_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    neg_nxt         = neg_r;
    dcnt_nxt        = dcnt_r;
    mem_we          = 1'b0;
    mem_addr        = cnt_r;
    mem_wdata       = data_r;
    q_pop           = 1'b0;
    out_load        = 1'b0;
    case (state_r)
      S_SWEEP: begin
        mem_we = 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) begin
          cnt_nxt      = '0;
          clearing_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (q_valid) begin
          q_pop    = 1'b1;
          data_nxt = q_item.value;
          case (q_item.kind)
            KIND_PUSH:   state_nxt = S_PUSH;
            KIND_REPORT: state_nxt = S_SUM;
            KIND_FILL:   state_nxt = S_SWEEP;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        mem_we    = 1'b1;
        mem_addr  = idx_eff[AW-1:0];
        idx_nxt   = idx_eff + 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (rvld_r) begin
          acc_nxt = acc_r + rdata_ext;
        end
        if (WW'(cnt_r) == win - 1'b1) begin
          state_nxt = S_LAST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LAST: begin
        acc_nxt   = acc_r + rdata_ext;
        state_nxt = S_DSETUP;
      end
      S_DSETUP: begin
        neg_nxt   = acc_r[SW-1];
        dvd_nxt   = acc_r[SW-1] ? (~acc_r + 1'b1) : acc_r;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // One restoring step: shift in a dividend bit, subtract if it fits.
        if (rem_sh >= win_ext) begin
          rem_nxt = WW'(rem_sh - win_ext);
          dvd_nxt = {dvd_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[WW-1:0];
          dvd_nxt = {dvd_r[SW-2:0], 1'b0};
        end
        if (dcnt_r == DCW'(SW - 1)) begin
          state_nxt = S_OUT;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: the quotient magnitude gets the sign of the sum.
  assign out_average_nxt = neg_r ? (~dvd_r[31:0] + 32'd1) : dvd_r[31:0];
  assign out_valid_nxt   = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      cnt_r       <= '0;
      idx_r       <= '0;
      clearing_r  <= 1'b1;
      data_r      <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      clearing_r  <= clearing_nxt;
      data_r      <= data_nxt;
      rvld_r      <= (state_r == S_SUM);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    dcnt_r <= dcnt_nxt;
    if (out_load) begin
      out_average_r <= out_average_nxt;
    end
  end

  // Single-port store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  assign status.clearing = clearing_r;
  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;

endmodule

`default_nettype wire

[hw/rtl/windowed_moving_average_core.sv]
// Top level of the windowed moving average block: config register, front,
// command queue and back part. Depends on wma_pkg, wma_front, wma_queue, wma_back.
`default_nettype none
`include "windowed_moving_average_core_defines.svh"

// Moving average of signed Q16.16 samples over a window of 1..DEPTH stored
// entries. A push request writes a sample and returns the truncated mean, a
// report request returns the mean alone, and a fill request sets every entry.
// Requests are classified and queued up to two deep, so input is taken while
// the back part works or a result waits. After reset the store is cleared in a
// pass over all DEPTH entries during which in_ready stays low. The back part
// has one store port, walks the window one entry per cycle and divides one
// quotient bit per cycle. The window register is written through cfg_we and
// cfg_wdata; the user must write it only while idle, as the block does not
// enforce this.
module windowed_moving_average_core #(
  parameter int DEPTH = wma_pkg::DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_operation,
  input  wire logic signed [31:0]  in_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_average,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);
  import wma_pkg::*;

  logic [CFG_W-1:0] window_length_r;
  logic             q_push;
  logic             q_ready;
  logic             q_pop;
  logic             q_valid;
  queue_item_t      q_item_in;
  queue_item_t      q_head;
  back_status_t     status;

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_length_r <= cfg_wdata;
    end
  end

  wma_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .status       (status),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_item       (q_item_in)
  );

  wma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  wma_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_length (window_length_r),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average)
  );

  // The queue never takes a command when full, nor gives one when empty.
  `WMA_ASSERT_NEVER(a_no_overflow, clk, rst_n, q_push && !q_ready)
  `WMA_ASSERT_IMPLIES(a_pop_valid, clk, rst_n, q_pop, q_valid)
  // No request may reach the queue during the clearing pass.
  `WMA_ASSERT_IMPLIES(a_clear_empty, clk, rst_n, status.clearing, !q_valid && !in_ready)

endmodule

`default_nettype wire
